@@ rtl/divider_timer_and_serial_shift_tick_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the divider / timer / serial tick block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DIVIDER_TIMER_AND_SERIAL_SHIFT_TICK_ASSERT_SVH
`define DIVIDER_TIMER_AND_SERIAL_SHIFT_TICK_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DTS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// next-cycle implication
`define DTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define DTS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define DTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/dts_pkg.sv @@
// ----------------------------------------------------------------------------
// dts_pkg
// Types, register indexes and constants shared by the tick block.
// ----------------------------------------------------------------------------
`default_nettype none
package dts_pkg;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} op_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RATE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RELOAD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_PERIOD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERNAL_CLOCK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_CONNECTED = 3'd5;

	localparam logic [12:0] SHIFT_PERIOD_RESET = 13'd512;
	localparam logic [10:0] TIMER_PRESCALE_MAX = 11'h7FF;
	localparam logic [12:0] SHIFT_PRESCALE_MAX = 13'h1FFF;
	localparam logic [3:0]  SHIFTS_PER_BYTE    = 4'd8;
	localparam logic [7:0]  DISCONNECTED_BYTE  = 8'hFF;

	typedef struct packed {
		op_t        op;
		logic [7:0] elapsed_clocks;
		logic [7:0] start_byte;
	} item_t;

	typedef struct packed {
		logic        timer_enable;
		logic [1:0]  timer_rate_select;
		logic [7:0]  timer_reload;
		logic [12:0] serial_shift_period;
		logic        serial_internal_clock;
		logic        link_connected;
	} cfg_t;

	function automatic logic [10:0] timer_period(input logic [1:0] rate);
		logic [10:0] p;
		unique case (rate)
			2'd0: p = 11'd1024;
			2'd1: p = 11'd16;
			2'd2: p = 11'd64;
			2'd3: p = 11'd256;
			default: p = 11'd1024;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

@@ rtl/dts_timer.sv @@
// ----------------------------------------------------------------------------
// dts_timer
// Free-running divider and programmable timer counter, one step per item.
// ----------------------------------------------------------------------------
`default_nettype none
module dts_timer import dts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  item_t      item,
	input  cfg_t       cfg,
	output logic [7:0] divider_value,
	output logic [7:0] timer_value,
	output logic       timer_irq
);

	logic [7:0]  div_pre_q;
	logic [7:0]  div_q;
	logic [10:0] tim_pre_q;
	logic [7:0]  tim_cnt_q;
	logic        tirq_q;

	logic [8:0]  div_sum;
	logic [11:0] tim_sum;
	logic [10:0] tim_sat;
	logic [10:0] period;
	logic        tim_hit;
	logic [7:0]  cnt_inc;

	always_comb begin
		div_sum = {1'b0, div_pre_q} + {1'b0, item.elapsed_clocks};
		tim_sum = {1'b0, tim_pre_q} + {4'b0, item.elapsed_clocks};
		tim_sat = tim_sum[11] ? TIMER_PRESCALE_MAX : tim_sum[10:0];
		period  = timer_period(cfg.timer_rate_select);
		tim_hit = (tim_sat >= period);
		cnt_inc = tim_cnt_q + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_pre_q <= '0;
			div_q     <= '0;
			tim_pre_q <= '0;
			tim_cnt_q <= '0;
			tirq_q    <= 1'b0;
		end else if (fire) begin
			tirq_q <= 1'b0;
			if (item.op == OP_TICK) begin
				// sum below 512: the carry is the once-per-256 bump
				div_pre_q <= div_sum[7:0];
				if (div_sum[8]) begin
					div_q <= div_q + 8'd1;
				end
				if (cfg.timer_enable) begin
					tim_pre_q <= tim_hit ? (tim_sat - period) : tim_sat;
					if (tim_hit) begin
						if (cnt_inc == 8'd0) begin
							tim_cnt_q <= cfg.timer_reload;
							tirq_q    <= 1'b1;
						end else begin
							tim_cnt_q <= cnt_inc;
						end
					end
				end
			end
		end
	end

	assign divider_value = div_q;
	assign timer_value   = tim_cnt_q;
	assign timer_irq     = tirq_q;

endmodule
`default_nettype wire

@@ rtl/dts_serial.sv @@
// ----------------------------------------------------------------------------
// dts_serial
// Serial shift register with its own prescaler and eight-shift transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module dts_serial import dts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  item_t      item,
	input  cfg_t       cfg,
	output logic [7:0] serial_data,
	output logic       serial_busy,
	output logic       serial_irq
);

	logic [12:0] pre_q;
	logic [3:0]  rem_q;
	logic [7:0]  data_q;
	logic        busy_q;
	logic        sirq_q;

	logic [12:0] period;
	logic [13:0] sum;
	logic [12:0] sat;
	logic        hit;
	logic [3:0]  rem_dec;

	always_comb begin
		period  = (cfg.serial_shift_period == 13'd0) ? 13'd1 : cfg.serial_shift_period;
		sum     = {1'b0, pre_q} + {6'b0, item.elapsed_clocks};
		sat     = sum[13] ? SHIFT_PRESCALE_MAX : sum[12:0];
		hit     = (sat >= period);
		rem_dec = rem_q - 4'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q  <= '0;
			rem_q  <= '0;
			data_q <= '0;
			busy_q <= 1'b0;
			sirq_q <= 1'b0;
		end else if (fire) begin
			sirq_q <= 1'b0;
			if (item.op == OP_START) begin
				// restart even if a transfer is running
				data_q <= item.start_byte;
				rem_q  <= SHIFTS_PER_BYTE;
				pre_q  <= '0;
				busy_q <= 1'b1;
			end else if (rem_q != 4'd0) begin
				pre_q <= hit ? (sat - period) : sat;
				if (hit) begin
					rem_q <= rem_dec;
					if (rem_dec == 4'd0) begin
						busy_q <= 1'b0;
						if (cfg.serial_internal_clock && !cfg.link_connected) begin
							data_q <= DISCONNECTED_BYTE;
							sirq_q <= 1'b1;
						end else begin
							data_q <= {data_q[6:0], 1'b0};
						end
					end else begin
						data_q <= {data_q[6:0], 1'b0};
					end
				end
			end
		end
	end

	assign serial_data = data_q;
	assign serial_busy = busy_q;
	assign serial_irq  = sirq_q;

endmodule
`default_nettype wire

@@ rtl/divider_timer_and_serial_shift_tick.sv @@
// ----------------------------------------------------------------------------
// divider_timer_and_serial_shift_tick
// Divider, programmable timer and serial shifter stepped by tick transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (tick_valid / tick_stall) carries op, elapsed_clocks and
//   start_byte. op = tick adds elapsed clocks to the divider, timer and
//   shifter prescalers; op = start loads start_byte and begins an
//   eight-shift serial transfer.
//   Result channel (result_valid / result_stall) returns one transaction per
//   input: divider, timer and serial state after that item plus the timer
//   and serial interrupt pulses of that item.
//   The input register feeds the state registers, which double as the
//   result register.
//   Throughput is one transaction per cycle while result_stall is low; the
//   prescaler add/compare/subtract path is combinational before the state.
//   When the receiver stalls, the result holds and the state freezes; the
//   input register still takes a transaction if empty, then tick_stall rises.
//   Reset clears all counters, the shifter and both valid flags, and loads
//   the configuration defaults (shift period 512, internal clock). The user
//   makes configuration writes (cfg_write_en, cfg_index, cfg_data) only
//   while the block is idle (unenforced); they take effect at the next edge.
// ----------------------------------------------------------------------------
`default_nettype none
`include "divider_timer_and_serial_shift_tick_assert.svh"
module divider_timer_and_serial_shift_tick import dts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// tick channel
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  logic                  op,
	input  logic [7:0]            elapsed_clocks,
	input  logic [7:0]            start_byte,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [7:0]            divider_value,
	output logic [7:0]            timer_value,
	output logic                  timer_irq,
	output logic [7:0]            serial_data,
	output logic                  serial_busy,
	output logic                  serial_irq
);

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	logic  valid_q;
	logic  tick_accept;
	logic  fire;

	// Configuration registers: mask to width, ignore unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timer_enable          <= 1'b0;
			cfg_q.timer_rate_select     <= 2'd0;
			cfg_q.timer_reload          <= 8'd0;
			cfg_q.serial_shift_period   <= SHIFT_PERIOD_RESET;
			cfg_q.serial_internal_clock <= 1'b1;
			cfg_q.link_connected        <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_TIMER_ENABLE:   cfg_q.timer_enable          <= cfg_data[0];
				CFG_TIMER_RATE:     cfg_q.timer_rate_select     <= cfg_data[1:0];
				CFG_TIMER_RELOAD:   cfg_q.timer_reload          <= cfg_data[7:0];
				CFG_SHIFT_PERIOD:   cfg_q.serial_shift_period   <= cfg_data;
				CFG_INTERNAL_CLOCK: cfg_q.serial_internal_clock <= cfg_data[0];
				CFG_LINK_CONNECTED: cfg_q.link_connected        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage one advances whenever the result slot is free or being taken.
	assign fire        = valid_s1 && !(valid_q && result_stall);
	assign tick_stall  = valid_s1 && valid_q && result_stall;
	assign tick_accept = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload needs no reset.
	always_ff @(posedge clk) begin
		if (tick_accept) begin
			item_s1.op             <= op_t'(op);
			item_s1.elapsed_clocks <= elapsed_clocks;
			item_s1.start_byte     <= start_byte;
		end
	end

	// Result valid: set on each state update, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	// State only moves on fire, so it holds steady as the stalled result.
	dts_timer u_timer (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.cfg           (cfg_q),
		.divider_value (divider_value),
		.timer_value   (timer_value),
		.timer_irq     (timer_irq)
	);

	dts_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.cfg         (cfg_q),
		.serial_data (serial_data),
		.serial_busy (serial_busy),
		.serial_irq  (serial_irq)
	);

	assign result_valid = valid_q;

	// A completed unconnected transfer leaves the shifter idle and all ones.
	`DTS_ASSERT_IMPLIES(a_sirq_done, clk, arst_n, valid_q && serial_irq, !serial_busy && serial_data == DISCONNECTED_BYTE)
	// A timer wrap leaves the counter at the reload value.
	`DTS_ASSERT_IMPLIES(a_tirq_reload, clk, arst_n, valid_q && timer_irq, timer_value == cfg_q.timer_reload)
	// A held result freezes the divider and the serial data.
	`DTS_ASSERT_NEXT(a_hold_div, clk, arst_n, valid_q && result_stall, $stable(divider_value) && $stable(serial_data))

endmodule
`default_nettype wire
